[rtl/bap_pkg.sv]
// Shared types, codes and helpers for the byte alphabet packer.
// No dependencies; imported by bap_ram, byte_alphabet_packer and tb_top.
`timescale 1ns / 1ps

package bap_pkg;

  // one stored byte
  typedef logic [7:0] byte_t;

  // width of the out_length field
  localparam int unsigned OUT_LEN_W = 11;

  // command codes carried by opcode
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  // status codes returned with each result word
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DROP  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // bits needed to hold v (zero for zero)
  function automatic logic [3:0] bits_needed(input logic [7:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        r = 4'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

[rtl/byte_alphabet_packer.sv]
// Byte alphabet packer top level: command decode, sequencer and output register.
// Depends on bap_pkg and bap_ram.
`timescale 1ns / 1ps

// Every command word gives exactly one result word. Clear, unused commands
// and loads without last_byte are answered straight from the idle state. A
// read of a raw byte or of a table byte goes through one registered RAM read.
// A read of a packed data byte walks its eight bits one per cycle after the
// accept cycle and pauses each time it reaches a new source byte to fetch its
// code (byte store read, then code table read).
// A load that carries last_byte starts compression: a scan of the byte store
// at one byte per cycle, then, unless the alphabet is empty or full, a pass over
// all 256 byte values that assigns codes over the seen map and a product and
// compare to size the packed form. The byte store has a single read port.
module byte_alphabet_packer
  import bap_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 packed_res_o,
  output logic [OUT_LEN_W-1:0] out_length_o,
  output logic [1:0]           status_o
);

  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);
  localparam int unsigned AW    = $clog2(MAX_BYTES);
  localparam int unsigned TOT_W = ((CNT_W > 9) ? CNT_W : 9) + 2;
  localparam int unsigned PRD_W = CNT_W + 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WIDTH,
    ST_ASSIGN,
    ST_SIZE,
    ST_CMP,
    ST_RD_RAW,
    ST_RD_TAB,
    ST_BIT,
    ST_BIT_C,
    ST_BIT_W
  } state_e;

  state_e             state_q;
  logic               out_phase_q;
  logic [CNT_W-1:0]   loaded_q;
  logic [8:0]         distinct_q;
  logic [3:0]         cw_q;
  logic [CNT_W-1:0]   rd_idx_q;
  logic               packed_q;
  logic [CNT_W-1:0]   total_len_q;
  logic [255:0]       seen_q;
  logic [CNT_W-1:0]   scan_idx_q;
  logic               scan_pend_q;
  logic [7:0]         asg_idx_q;
  logic [7:0]         asg_code_q;
  logic [PRD_W-1:0]   prod_q;
  logic [CNT_W:0]     elem_q;
  logic [2:0]         off_q;
  byte_t              code_q;
  logic               code_ok_q;
  logic [2:0]         bit_cnt_q;
  logic [6:0]         acc_q;
  status_e            pend_status_q;
  logic               pend_last_q;

  logic               out_valid_q;
  byte_t              out_byte_q;
  logic               out_last_q;
  logic               out_packed_q;
  logic [OUT_LEN_W-1:0] out_len_q;
  status_e            out_status_q;

  // memory ports
  logic               bs_we;
  logic [AW-1:0]      bs_raddr;
  byte_t              bs_rdata;
  logic               tab_we;
  byte_t              cm_rdata;
  byte_t              vt_rdata;
  byte_t              vt_raddr;

  logic               accept_in;
  logic               has_room;
  logic               res_packed;
  logic [OUT_LEN_W-1:0] res_len;
  logic [3:0]         bit_sel;
  logic               elem_past;
  logic               bit_val;
  logic               bit_take;
  logic               wrap_code;
  logic [TOT_W-1:0]   body_len;
  logic [TOT_W-1:0]   pack_total;
  logic               pack_wins;

  // input handshake: idle with the output slot free or freeing
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept_in  = in_valid_i && in_ready_o;
  assign has_room   = loaded_q < CNT_W'(MAX_BYTES);

  // result fields that follow the phase
  assign res_packed = out_phase_q ? packed_q : 1'b0;
  assign res_len    = out_phase_q ? OUT_LEN_W'(total_len_q) : '0;

  // byte store: written on load, read by scan, raw reads and the bit walk
  assign bs_we = accept_in && (opcode_i == OP_LOAD) && !out_phase_q && has_room;

  always_comb begin
    case (state_q)
      ST_SCAN: bs_raddr = scan_idx_q[AW-1:0];
      ST_BIT:  bs_raddr = elem_q[AW-1:0];
      default: bs_raddr = rd_idx_q[AW-1:0];
    endcase
  end

  bap_ram #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_byte_store (
    .clk_i   (clk_i),
    .we_i    (bs_we),
    .waddr_i (loaded_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (bs_raddr),
    .rdata_o (bs_rdata)
  );

  // code and value tables, filled together during the assign pass
  assign tab_we   = (state_q == ST_ASSIGN) && seen_q[asg_idx_q];
  assign vt_raddr = 8'(rd_idx_q - CNT_W'(1));

  bap_ram #(
    .DEPTH (256),
    .AW    (8)
  ) u_code_map (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (asg_idx_q),
    .wdata_i (asg_code_q),
    .raddr_i (bs_rdata),
    .rdata_o (cm_rdata)
  );

  bap_ram #(
    .DEPTH (256),
    .AW    (8)
  ) u_value_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (asg_code_q),
    .wdata_i (asg_idx_q),
    .raddr_i (vt_raddr),
    .rdata_o (vt_rdata)
  );

  // bit walk: pick the current code bit, msb first
  assign bit_sel   = cw_q - 4'd1 - {1'b0, off_q};
  assign elem_past = elem_q >= {1'b0, loaded_q};
  assign bit_val   = elem_past ? 1'b0 : code_q[bit_sel[2:0]];
  assign bit_take  = (state_q == ST_BIT) && (elem_past || code_ok_q);
  assign wrap_code = ({1'b0, off_q} + 4'd1) == cw_q;

  // packed size from the registered product, rounded up at full product width
  assign body_len   = TOT_W'((prod_q + PRD_W'(7)) >> 3);
  assign pack_total = TOT_W'(1) + TOT_W'(distinct_q) + body_len;
  assign pack_wins  = pack_total < TOT_W'(loaded_q);

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_phase_q   <= 1'b0;
      loaded_q      <= '0;
      distinct_q    <= '0;
      cw_q          <= '0;
      rd_idx_q      <= '0;
      packed_q      <= 1'b0;
      total_len_q   <= '0;
      seen_q        <= '0;
      scan_idx_q    <= '0;
      scan_pend_q   <= 1'b0;
      asg_idx_q     <= '0;
      asg_code_q    <= '0;
      prod_q        <= '0;
      elem_q        <= '0;
      off_q         <= '0;
      code_q        <= '0;
      code_ok_q     <= 1'b0;
      bit_cnt_q     <= '0;
      acc_q         <= '0;
      pend_status_q <= STATUS_OK;
      pend_last_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      out_byte_q    <= '0;
      out_last_q    <= 1'b0;
      out_packed_q  <= 1'b0;
      out_len_q     <= '0;
      out_status_q  <= STATUS_OK;
    end else begin
      // output word taken with no command accepted in the same cycle
      if (out_valid_q && out_ready_i && !accept_in) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept_in) begin
            case (opcode_i)
              OP_LOAD: begin
                if (out_phase_q) begin
                  out_valid_q  <= 1'b1;
                  out_byte_q   <= '0;
                  out_last_q   <= 1'b0;
                  out_packed_q <= res_packed;
                  out_len_q    <= res_len;
                  out_status_q <= STATUS_DROP;
                end else begin
                  if (has_room) begin
                    loaded_q <= loaded_q + CNT_W'(1);
                  end
                  if (last_byte_i) begin
                    // start compression on what is held
                    out_valid_q   <= 1'b0;
                    seen_q        <= '0;
                    distinct_q    <= '0;
                    scan_idx_q    <= '0;
                    scan_pend_q   <= 1'b0;
                    pend_status_q <= has_room ? STATUS_OK : STATUS_DROP;
                    state_q       <= ST_SCAN;
                  end else begin
                    out_valid_q  <= 1'b1;
                    out_byte_q   <= '0;
                    out_last_q   <= 1'b0;
                    out_packed_q <= 1'b0;
                    out_len_q    <= '0;
                    out_status_q <= has_room ? STATUS_OK : STATUS_DROP;
                  end
                end
              end
              OP_READ: begin
                if (out_phase_q && (rd_idx_q < total_len_q)) begin
                  rd_idx_q    <= rd_idx_q + CNT_W'(1);
                  pend_last_q <= (rd_idx_q + CNT_W'(1)) == total_len_q;
                  if (!packed_q) begin
                    out_valid_q <= 1'b0;
                    state_q     <= ST_RD_RAW;
                  end else if (rd_idx_q == '0) begin
                    // count byte
                    out_valid_q  <= 1'b1;
                    out_byte_q   <= distinct_q[7:0];
                    out_last_q   <= (rd_idx_q + CNT_W'(1)) == total_len_q;
                    out_packed_q <= res_packed;
                    out_len_q    <= res_len;
                    out_status_q <= STATUS_OK;
                  end else if (TOT_W'(rd_idx_q) <= TOT_W'(distinct_q)) begin
                    out_valid_q <= 1'b0;
                    state_q     <= ST_RD_TAB;
                  end else if (cw_q == '0) begin
                    out_valid_q  <= 1'b1;
                    out_byte_q   <= '0;
                    out_last_q   <= (rd_idx_q + CNT_W'(1)) == total_len_q;
                    out_packed_q <= res_packed;
                    out_len_q    <= res_len;
                    out_status_q <= STATUS_OK;
                  end else begin
                    out_valid_q <= 1'b0;
                    bit_cnt_q   <= '0;
                    state_q     <= ST_BIT;
                  end
                end else begin
                  out_valid_q  <= 1'b1;
                  out_byte_q   <= '0;
                  out_last_q   <= 1'b0;
                  out_packed_q <= res_packed;
                  out_len_q    <= res_len;
                  out_status_q <= STATUS_EMPTY;
                end
              end
              OP_CLEAR: begin
                out_phase_q  <= 1'b0;
                loaded_q     <= '0;
                distinct_q   <= '0;
                cw_q         <= '0;
                rd_idx_q     <= '0;
                packed_q     <= 1'b0;
                total_len_q  <= '0;
                seen_q       <= '0;
                out_valid_q  <= 1'b1;
                out_byte_q   <= '0;
                out_last_q   <= 1'b0;
                out_packed_q <= 1'b0;
                out_len_q    <= '0;
                out_status_q <= STATUS_OK;
              end
              default: begin
                out_valid_q  <= 1'b1;
                out_byte_q   <= '0;
                out_last_q   <= 1'b0;
                out_packed_q <= res_packed;
                out_len_q    <= res_len;
                out_status_q <= STATUS_OK;
              end
            endcase
          end
        end

        // one store read issued per cycle; the registered read data marks the seen map
        ST_SCAN: begin
          scan_pend_q <= scan_idx_q < loaded_q;
          if (scan_idx_q < loaded_q) begin
            scan_idx_q <= scan_idx_q + CNT_W'(1);
          end
          if (scan_pend_q && !seen_q[bs_rdata]) begin
            seen_q[bs_rdata] <= 1'b1;
            distinct_q       <= distinct_q + 9'd1;
          end
          if ((scan_idx_q == loaded_q) && !scan_pend_q) begin
            state_q <= ST_WIDTH;
          end
        end

        ST_WIDTH: begin
          out_phase_q <= 1'b1;
          rd_idx_q    <= '0;
          packed_q    <= 1'b0;
          total_len_q <= loaded_q;
          if ((distinct_q == '0) || distinct_q[8]) begin
            // empty or full alphabet stays raw
            cw_q         <= '0;
            out_valid_q  <= 1'b1;
            out_byte_q   <= '0;
            out_last_q   <= 1'b0;
            out_packed_q <= 1'b0;
            out_len_q    <= OUT_LEN_W'(loaded_q);
            out_status_q <= pend_status_q;
            state_q      <= ST_IDLE;
          end else begin
            cw_q       <= bits_needed(8'(distinct_q - 9'd1));
            asg_idx_q  <= '0;
            asg_code_q <= '0;
            state_q    <= ST_ASSIGN;
          end
        end

        // dense codes in ascending value order
        ST_ASSIGN: begin
          if (seen_q[asg_idx_q]) begin
            asg_code_q <= asg_code_q + 8'd1;
          end
          if (asg_idx_q == 8'hFF) begin
            state_q <= ST_SIZE;
          end else begin
            asg_idx_q <= asg_idx_q + 8'd1;
          end
        end

        ST_SIZE: begin
          prod_q  <= PRD_W'(cw_q) * PRD_W'(loaded_q);
          state_q <= ST_CMP;
        end

        ST_CMP: begin
          elem_q    <= '0;
          off_q     <= '0;
          code_ok_q <= 1'b0;
          if (pack_wins) begin
            packed_q    <= 1'b1;
            total_len_q <= CNT_W'(pack_total);
          end
          out_valid_q  <= 1'b1;
          out_byte_q   <= '0;
          out_last_q   <= 1'b0;
          out_packed_q <= pack_wins;
          out_len_q    <= pack_wins ? OUT_LEN_W'(pack_total) : OUT_LEN_W'(loaded_q);
          out_status_q <= pend_status_q;
          state_q      <= ST_IDLE;
        end

        ST_RD_RAW: begin
          out_valid_q  <= 1'b1;
          out_byte_q   <= bs_rdata;
          out_last_q   <= pend_last_q;
          out_packed_q <= res_packed;
          out_len_q    <= res_len;
          out_status_q <= STATUS_OK;
          state_q      <= ST_IDLE;
        end

        ST_RD_TAB: begin
          out_valid_q  <= 1'b1;
          out_byte_q   <= vt_rdata;
          out_last_q   <= pend_last_q;
          out_packed_q <= res_packed;
          out_len_q    <= res_len;
          out_status_q <= STATUS_OK;
          state_q      <= ST_IDLE;
        end

        // one code bit per cycle; fetch the code when the source byte changes
        ST_BIT: begin
          if (bit_take) begin
            acc_q     <= {acc_q[5:0], bit_val};
            bit_cnt_q <= bit_cnt_q + 3'd1;
            if (wrap_code) begin
              off_q     <= '0;
              elem_q    <= elem_q + (CNT_W + 1)'(1);
              code_ok_q <= 1'b0;
            end else begin
              off_q <= off_q + 3'd1;
            end
            if (bit_cnt_q == 3'd7) begin
              out_valid_q  <= 1'b1;
              out_byte_q   <= {acc_q, bit_val};
              out_last_q   <= pend_last_q;
              out_packed_q <= res_packed;
              out_len_q    <= res_len;
              out_status_q <= STATUS_OK;
              state_q      <= ST_IDLE;
            end
          end else begin
            state_q <= ST_BIT_C;
          end
        end

        ST_BIT_C: begin
          state_q <= ST_BIT_W;
        end

        ST_BIT_W: begin
          code_q    <= cm_rdata;
          code_ok_q <= 1'b1;
          state_q   <= ST_BIT;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign packed_res_o = out_packed_q;
  assign out_length_o = out_len_q;
  assign status_o     = out_status_q;

`ifndef NO_ASSERTIONS
  // alphabet count never passes the number of byte values
  assert property (@(posedge clk_i) disable iff (!rst_ni) distinct_q <= 9'd256)
    else $error("distinct count above 256");

  // bit offset stays inside the code during the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BIT) |-> ({1'b0, off_q} < cw_q))
    else $error("bit offset outside code width");

  // read pointer never runs past the output length
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_idx_q <= total_len_q)
    else $error("read index past output length");

  // a final output word always comes with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (status_o == STATUS_OK))
    else $error("last word with error status");
`endif

endmodule

[rtl/bap_ram.sv]
// Simple dual-port byte RAM: one write port, one registered read port.
// Depends on bap_pkg for the byte type.
`timescale 1ns / 1ps

module bap_ram
  import bap_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  byte_t         wdata_i,
  input  logic [AW-1:0] raddr_i,
  output byte_t         rdata_o
);

  byte_t mem_q [DEPTH];
  byte_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[verif/tb_top.sv]
// Self-checking bench for byte_alphabet_packer: command words in, one result word out each.
// Predicts untyped results from its own copy of the packer state; depends on bap_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import bap_pkg::*;

  localparam int unsigned CAPACITY = 1024;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_DIRECTED = 24;

  typedef struct packed {
    byte_t                 out_byte;
    logic                  out_last;
    logic                  is_packed;
    logic [OUT_LEN_W-1:0]  out_len;
    status_e               status;
  } pack_result_t;

  typedef struct packed {
    logic [1:0]   op;
    byte_t        data;
    logic         last;
    logic         typed;
    pack_result_t want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           opcode_i;
  logic [7:0]           data_byte_i;
  logic                 last_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           out_byte_o;
  logic                 out_last_o;
  logic                 packed_res_o;
  logic [OUT_LEN_W-1:0] out_length_o;
  logic [1:0]           status_o;

  // predicted packer state
  byte_t       pack_store [CAPACITY];
  logic        pack_seen [256];
  byte_t       pack_code [256];
  byte_t       pack_alpha [256];
  int unsigned pack_loaded;
  int unsigned pack_distinct;
  int unsigned pack_width;
  int unsigned pack_rd_idx;
  int unsigned pack_total;
  logic        pack_draining;
  logic        pack_is_packed;

  pack_result_t expected_words [$];
  int unsigned  mismatches = 0;
  int unsigned  words_sent = 0;
  int unsigned  idle_pct = 20;
  int unsigned  stall_pct = 20;
  int unsigned  stall_left = 0;

  // directed words: expected result typed in where it is obvious
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_READ,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_EMPTY}},
    '{OP_UNUSED, 8'hA5, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd3, STATUS_OK}},
    '{OP_READ,   8'h5A, 1'b1, 1'b1, '{8'hFF, 1'b0, 1'b0, 11'd3, STATUS_OK}},
    '{OP_READ,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd3, STATUS_OK}},
    '{OP_READ,   8'h00, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 11'd3, STATUS_OK}},
    '{OP_READ,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd3, STATUS_EMPTY}},
    '{OP_LOAD,   8'h12, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd3, STATUS_DROP}},
    '{OP_UNUSED, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd3, STATUS_OK}},
    '{OP_CLEAR,  8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'hAA, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'hAA, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'hAA, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'hAA, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'hAA, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 11'd2, STATUS_OK}},
    '{OP_READ,   8'h00, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b1, 11'd2, STATUS_OK}},
    '{OP_READ,   8'h00, 1'b0, 1'b1, '{8'hAA, 1'b1, 1'b1, 11'd2, STATUS_OK}},
    '{OP_READ,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 11'd2, STATUS_EMPTY}},
    '{OP_CLEAR,  8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}},
    '{OP_LOAD,   8'h3C, 1'b1, 1'b0, '0},
    '{OP_READ,   8'hC3, 1'b0, 1'b0, '0},
    '{OP_CLEAR,  8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 11'd0, STATUS_OK}}
  };

  byte_alphabet_packer #(
    .MAX_BYTES(CAPACITY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .packed_res_o(packed_res_o),
    .out_length_o(out_length_o),
    .status_o    (status_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // back to the empty loading state
  function automatic void pack_clear();
    int i;
    for (i = 0; i < 256; i++) begin
      pack_seen[i] = 1'b0;
    end
    pack_loaded    = 0;
    pack_distinct  = 0;
    pack_width     = 0;
    pack_rd_idx    = 0;
    pack_total     = 0;
    pack_draining  = 1'b0;
    pack_is_packed = 1'b0;
  endfunction

  // count distinct values, assign dense codes, size the packed form
  function automatic void pack_compress();
    int unsigned i, c, body_len;
    for (i = 0; i < 256; i++) begin
      pack_seen[i] = 1'b0;
    end
    pack_distinct = 0;
    for (i = 0; i < pack_loaded; i++) begin
      if (!pack_seen[pack_store[i]]) begin
        pack_seen[pack_store[i]] = 1'b1;
        pack_distinct++;
      end
    end
    pack_draining  = 1'b1;
    pack_rd_idx    = 0;
    pack_is_packed = 1'b0;
    pack_total     = pack_loaded;
    pack_width     = 0;
    // an empty alphabet stays raw, and a full alphabet cannot shrink
    if (pack_distinct == 0 || pack_distinct >= 256) begin
      return;
    end
    pack_width = $clog2(pack_distinct);
    c = 0;
    for (i = 0; i < 256; i++) begin
      if (pack_seen[i]) begin
        pack_code[i]  = byte_t'(c);
        pack_alpha[c] = byte_t'(i);
        c++;
      end
    end
    body_len = (pack_width * pack_loaded + 7) / 8;
    if (1 + pack_distinct + body_len < pack_loaded) begin
      pack_is_packed = 1'b1;
      pack_total     = 1 + pack_distinct + body_len;
    end
  endfunction

  // byte r of the packed form: count, alphabet, then codes msb first
  function automatic byte_t packed_at(input int unsigned r);
    int unsigned k, p, e, b;
    byte_t acc;
    byte_t code;
    if (r == 0) begin
      return byte_t'(pack_distinct);
    end
    if (r <= pack_distinct) begin
      return pack_alpha[r - 1];
    end
    if (pack_width == 0) begin
      return 8'h00;
    end
    k = r - 1 - pack_distinct;
    acc = 8'h00;
    for (b = 0; b < 8; b++) begin
      p = k * 8 + b;
      e = p / pack_width;
      if (e < pack_loaded) begin
        code = pack_code[pack_store[e]];
        acc = {acc[6:0], code[pack_width - 1 - p % pack_width]};
      end else begin
        acc = {acc[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // result word for one command word, advancing the predicted state
  function automatic pack_result_t predict_word(input logic [1:0] op, input byte_t data,
                                                input logic last);
    pack_result_t r;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      OP_LOAD: begin
        if (pack_draining) begin
          r.status = STATUS_DROP;
        end else begin
          if (pack_loaded < CAPACITY) begin
            pack_store[pack_loaded] = data;
            pack_loaded++;
          end else begin
            r.status = STATUS_DROP;
          end
          if (last) begin
            pack_compress();
          end
        end
      end
      OP_READ: begin
        if (pack_draining && pack_rd_idx < pack_total) begin
          r.out_byte = pack_is_packed ? packed_at(pack_rd_idx) : pack_store[pack_rd_idx];
          pack_rd_idx++;
          r.out_last = (pack_rd_idx == pack_total);
        end else begin
          r.status = STATUS_EMPTY;
        end
      end
      OP_CLEAR: begin
        pack_clear();
      end
      default: begin
      end
    endcase
    if (pack_draining) begin
      r.is_packed = pack_is_packed;
      r.out_len   = pack_total[OUT_LEN_W-1:0];
    end
    return r;
  endfunction

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // present one word at the falling edge and hold it until accepted
  task automatic send_word(input logic [1:0] op, input byte_t data, input logic last,
                           input logic typed = 1'b0, input pack_result_t want = '0);
    pack_result_t r;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    r = predict_word(op, data, last);
    expected_words.push_back(typed ? want : r);
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= data;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // stray word: unused code, or a command the current phase rejects
  task automatic send_noise(input logic draining);
    logic [1:0] op;
    op = $urandom_range(0, 1) ? OP_UNUSED : (draining ? OP_LOAD : OP_READ);
    send_word(op, byte_t'($urandom), 1'($urandom));
  endtask

  // load a buffer drawn from a random alphabet, then drain the output
  task automatic run_alphabet_job(input int unsigned n_loads, input int unsigned n_syms,
                                  input int unsigned max_reads);
    byte_t syms [256];
    byte_t tmp;
    byte_t value;
    int unsigned i, j, n_reads, abort_at, cut_at;
    for (i = 0; i < 256; i++) begin
      syms[i] = byte_t'(i);
    end
    for (i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = syms[i];
      syms[i] = syms[j];
      syms[j] = tmp;
    end
    // some short jobs are broken off by a clear while loading
    abort_at = (n_loads <= 200 && $urandom_range(0, 9) == 0) ?
               $urandom_range(0, n_loads - 1) : n_loads;
    for (i = 0; i < n_loads; i++) begin
      if (i == abort_at) begin
        send_word(OP_CLEAR, byte_t'($urandom), 1'($urandom));
        return;
      end
      if ($urandom_range(0, 99) < 4) begin
        send_noise(1'b0);
      end
      value = (i < n_syms) ? syms[i] : syms[$urandom_range(0, n_syms - 1)];
      send_word(OP_LOAD, value, logic'(i == n_loads - 1));
    end
    // drain, sometimes past the end, sometimes cut short
    n_reads = pack_total + $urandom_range(0, 2);
    if (n_reads > max_reads) begin
      n_reads = max_reads;
    end
    cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_reads) : n_reads;
    for (i = 0; i < cut_at; i++) begin
      if ($urandom_range(0, 99) < 4) begin
        send_noise(1'b1);
      end
      send_word(OP_READ, byte_t'($urandom), 1'($urandom));
    end
    send_word(OP_CLEAR, byte_t'($urandom), 1'($urandom));
  endtask

  // mostly short buffers, now and then a longer one
  task automatic run_small_job();
    int unsigned n, syms;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 200) : $urandom_range(1, 60);
    syms = $urandom_range(1, 1 << $urandom_range(0, 6));
    run_alphabet_job(n, syms, 1024);
  endtask

  // result side back-pressure in bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    pack_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        note_error($sformatf("unexpected result word: byte %02h status %0d",
                             out_byte_o, status_o));
      end else begin
        w = expected_words.pop_front();
        if (out_byte_o !== w.out_byte || out_last_o !== w.out_last ||
            packed_res_o !== w.is_packed || out_length_o !== w.out_len ||
            status_o !== w.status) begin
          note_error($sformatf({"mismatch: want byte %02h last %0d packed %0d len %0d",
                                " status %0d, got byte %02h last %0d packed %0d len %0d",
                                " status %0d"},
                               w.out_byte, w.out_last, w.is_packed, w.out_len, w.status,
                               out_byte_o, out_last_o, packed_res_o, out_length_o,
                               status_o));
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int i;
    int unsigned calm_target;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_LOAD;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    out_ready_i = 1'b0;
    pack_clear();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < N_DIRECTED; i++) begin
      send_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);
    end

    while (words_sent < 250) begin
      idle_pct  = 20 * $urandom_range(0, 3);
      stall_pct = 20 * $urandom_range(0, 3);
      run_small_job();
    end

    // full buffer with a dropped last byte and a full alphabet, seven bit codes
    idle_pct  = 20;
    stall_pct = 20;
    run_alphabet_job(1030, 256, 40);
    run_alphabet_job(540, 65, 90);

    // closing stretch at full rate
    idle_pct  = 0;
    stall_pct = 0;
    calm_target = words_sent + 150;
    while (words_sent < calm_target) begin
      run_small_job();
    end
    in_valid_i <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
